/* hdl/pge_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the packed glyph pixel expander.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pge_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BYTE   = 1'b1;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic        is_hdr;
    coord_t      org_x;
    coord_t      org_y;
    logic [7:0]  w;
    logic [15:0] area;
    logic [15:0] color;
    logic        draw_en;
    logic [7:0]  data;
  } job_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  function automatic logic [15:0] to_out16(coord_t v);
    return 16'($signed(v));
  endfunction

endpackage

/* hdl/pge_front.sv */
`timescale 1ns / 1ps
// Front end: keeps the pen position and turns each accepted beat into a job.
// Depends on pge_pkg.
module pge_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                opcode_i,
  input  logic                new_string_i,
  input  logic signed [15:0]  pen_x_i,
  input  logic signed [15:0]  pen_y_i,
  input  logic [7:0]          glyph_width_i,
  input  logic [7:0]          glyph_height_i,
  input  logic signed [7:0]   x_offset_i,
  input  logic signed [7:0]   y_offset_i,
  input  logic [7:0]          x_advance_i,
  input  logic [7:0]          scale_i,
  input  logic [15:0]         text_color_i,
  input  logic [7:0]          bitmap_byte_i,
  output pge_pkg::job_t       job_o
);

  pge_pkg::coord_t pen_x_q, pen_x_d;
  pge_pkg::coord_t pen_y_q, pen_y_d;
  pge_pkg::coord_t base_x, base_y;
  logic [15:0]     advance;
  logic            is_hdr;

  always_comb begin
    is_hdr  = (opcode_i == pge_pkg::OP_HEADER);
    base_x  = new_string_i ? pge_pkg::coord_t'(pen_x_i) : pen_x_q;
    base_y  = new_string_i ? pge_pkg::coord_t'(pen_y_i) : pen_y_q;
    advance = 16'(x_advance_i) * 16'(scale_i);
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (fire_i && is_hdr) begin
      pen_x_d = base_x + pge_pkg::coord_t'(advance);
      pen_y_d = base_y;
    end
  end

  always_comb begin
    job_o.is_hdr  = is_hdr;
    job_o.org_x   = base_x + pge_pkg::coord_t'(x_offset_i);
    job_o.org_y   = base_y + pge_pkg::coord_t'(y_offset_i);
    job_o.w       = glyph_width_i;
    job_o.area    = 16'(glyph_width_i) * 16'(glyph_height_i);
    job_o.color   = text_color_i;
    job_o.draw_en = (scale_i == 8'd1);
    job_o.data    = bitmap_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

endmodule

/* hdl/pge_queue.sv */
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the pixel back end.
// Depends on pge_pkg.
module pge_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  pge_pkg::job_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output pge_pkg::job_t rd_data_o,
  output logic          empty_o
);

  pge_pkg::job_t            mem_q [pge_pkg::QDepth];
  logic [pge_pkg::QAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [pge_pkg::QAw:0]    cnt_q, cnt_d;
  logic                     do_wr, do_rd;

  assign full_o    = (cnt_q == (pge_pkg::QAw+1)'(pge_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (pge_pkg::QAw+1)'(pge_pkg::QDepth))
    else $error("job queue count exceeds depth");

endmodule

/* hdl/pge_back.sv */
`timescale 1ns / 1ps
// Back end: applies glyph headers and steps through bitmap bytes one bit per
// cycle, stalling on a full two-entry pixel output buffer. Depends on pge_pkg.
module pge_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  pge_pkg::job_t q_data_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pge_pkg::pixel_t pix_o
);

  logic            active_q, active_d;
  logic [2:0]      idx_q, idx_d;
  logic [7:0]      emit_q, emit_d;
  logic            draw_en_q, draw_en_d;
  logic [7:0]      col_q, col_d;
  logic [7:0]      row_q, row_d;
  logic [15:0]     left_q, left_d;
  pge_pkg::coord_t org_x_q, org_x_d;
  pge_pkg::coord_t org_y_q, org_y_d;
  logic [7:0]      w_q, w_d;
  logic [15:0]     color_q, color_d;
  logic [7:0]      valid;

  pge_pkg::pixel_t ob_q [2];
  logic [1:0]      ob_cnt_q;
  logic            ob_wr_q, ob_rd_q;
  logic            pop_fire, can_push, emit_now, step, finish, push;
  pge_pkg::pixel_t pix_new;

  always_comb begin
    pop_fire = pop_i && (ob_cnt_q != 2'd0);
    can_push = (ob_cnt_q != 2'd2) || pop_fire;
    emit_now = emit_q[7];
    step     = active_q && (!emit_now || can_push);
    finish   = step && (idx_q == 3'd7);
    push     = step && emit_now;
    q_rd_o   = !q_empty_i && (!active_q || finish);
  end

  always_comb begin
    active_d  = active_q;
    idx_d     = idx_q;
    emit_d    = emit_q;
    draw_en_d = draw_en_q;
    col_d     = col_q;
    row_d     = row_q;
    left_d    = left_q;
    org_x_d   = org_x_q;
    org_y_d   = org_y_q;
    w_d       = w_q;
    color_d   = color_q;
    if (step) begin
      idx_d  = idx_q + 1'b1;
      emit_d = {emit_q[6:0], 1'b0};
      if (left_q != 16'd0) begin
        left_d = left_q - 1'b1;
        if (({1'b0, col_q} + 9'd1) >= {1'b0, w_q}) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      if (finish) begin
        active_d = 1'b0;
      end
    end
    for (int k = 0; k < 8; k++) begin
      valid[7-k] = (left_d > 16'(k));
    end
    if (q_rd_o) begin
      if (q_data_i.is_hdr) begin
        org_x_d   = q_data_i.org_x;
        org_y_d   = q_data_i.org_y;
        w_d       = q_data_i.w;
        color_d   = q_data_i.color;
        draw_en_d = q_data_i.draw_en;
        col_d     = '0;
        row_d     = '0;
        left_d    = q_data_i.area;
      end else begin
        active_d = 1'b1;
        idx_d    = '0;
        emit_d   = q_data_i.data & valid & {8{draw_en_q}};
      end
    end
  end

  always_comb begin
    pix_new.x     = pge_pkg::to_out16(org_x_q + pge_pkg::coord_t'(col_q));
    pix_new.y     = pge_pkg::to_out16(org_y_q + pge_pkg::coord_t'(row_q));
    pix_new.color = color_q;
    pix_new.last  = (emit_q[6:0] == 7'd0);
  end

  assign empty_o = (ob_cnt_q == 2'd0);
  assign pix_o   = ob_q[ob_rd_q];

  always_ff @(posedge clk_i) begin
    org_x_q <= org_x_d;
    org_y_q <= org_y_d;
    w_q     <= w_d;
    color_q <= color_d;
    if (push) begin
      ob_q[ob_wr_q] <= pix_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      idx_q     <= '0;
      emit_q    <= '0;
      draw_en_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      ob_cnt_q  <= '0;
      ob_wr_q   <= 1'b0;
      ob_rd_q   <= 1'b0;
    end else begin
      active_q  <= active_d;
      idx_q     <= idx_d;
      emit_q    <= emit_d;
      draw_en_q <= draw_en_d;
      col_q     <= col_d;
      row_q     <= row_d;
      left_q    <= left_d;
      if (push) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (pop_fire) begin
        ob_rd_q <= ~ob_rd_q;
      end
      ob_cnt_q <= ob_cnt_q + {1'b0, push} - {1'b0, pop_fire};
    end
  end

  a_ob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q <= 2'd2)
    else $error("output buffer count exceeds two");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && ob_cnt_q == 2'd2) |-> pop_fire)
    else $error("pixel written into a full output buffer");

  a_idle_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (emit_q == 8'd0))
    else $error("pending pixels left behind by a finished byte");

endmodule

/* hdl/packed_glyph_pixel_expander_core.sv */
`timescale 1ns / 1ps
// Packed glyph pixel expander top level: front end, job queue and back end.
// Depends on pge_pkg, pge_front, pge_queue and pge_back.
// The back end applies a header beat as it reads it and steps through a bitmap
// byte one bit per cycle while the output buffer has room, so the bit stepper
// sets the rate. A byte's first pixel passes the queue, bit stepper and output
// buffer. Async reset clears the pen, glyph counters and all queues at once.
module packed_glyph_pixel_expander_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               opcode_i,
  input  logic               new_string_i,
  input  logic signed [15:0] pen_x_i,
  input  logic signed [15:0] pen_y_i,
  input  logic [7:0]         glyph_width_i,
  input  logic [7:0]         glyph_height_i,
  input  logic signed [7:0]  x_offset_i,
  input  logic signed [7:0]  y_offset_i,
  input  logic [7:0]         x_advance_i,
  input  logic [7:0]         scale_i,
  input  logic [15:0]        text_color_i,
  input  logic [7:0]         bitmap_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic [15:0]        pixel_color_o,
  output logic               last_of_run_o
);

  pge_pkg::job_t   job, q_job;
  pge_pkg::pixel_t pix;
  logic            fire, q_empty, q_rd;

  assign fire = push && !full;

  pge_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .opcode_i       (opcode_i),
    .new_string_i   (new_string_i),
    .pen_x_i        (pen_x_i),
    .pen_y_i        (pen_y_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .x_offset_i     (x_offset_i),
    .y_offset_i     (y_offset_i),
    .x_advance_i    (x_advance_i),
    .scale_i        (scale_i),
    .text_color_i   (text_color_i),
    .bitmap_byte_i  (bitmap_byte_i),
    .job_o          (job)
  );

  pge_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (job),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_data_o (q_job),
    .empty_o   (q_empty)
  );

  pge_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_job),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .pix_o     (pix)
  );

  assign pixel_x_o     = pix.x;
  assign pixel_y_o     = pix.y;
  assign pixel_color_o = pix.color;
  assign last_of_run_o = pix.last;

endmodule
